@@ src/sqt_pkg.sv @@
// sqt_pkg: token kinds, scan modes, payload and queue entry types
// used by all sql_query_tokenizer modules; no dependencies
package sqt_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } sqt_in_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [31:0] token_first;
    logic [31:0] token_past_end;
    logic        run_last;
  } sqt_out_t;

  typedef enum logic [5:0] {
    K_EOS, K_WS, K_COMMENT, K_WORD, K_NUMBER, K_STRING, K_QID, K_LPAR,
    K_RPAR, K_LSQ, K_RSQ, K_COMMA, K_SEMI, K_DOT, K_STAR, K_PLUS,
    K_MINUS, K_SLASH, K_PERCENT, K_ARROW, K_QMARK, K_COLON, K_EQ, K_NE,
    K_LT, K_GT, K_LE, K_GE, K_CONCAT, K_ERR, K_ERR_BLOCK, K_ERR_SQ,
    K_ERR_DQ, K_ERR_BQ, K_ERR_BANG, K_ERR_PIPE, K_ERR_NUM
  } kind_t;

  typedef enum logic [4:0] {
    M_IDLE, M_WS, M_WORD, M_ZERO, M_INT, M_FRAC, M_ESIGN, M_EDIG, M_BAD,
    M_AFTERDOT, M_DOTPEND, M_DN_INT, M_DN_ESIGN, M_DN_EDIG, M_MINUS,
    M_SLASH, M_EQ, M_BANG, M_LT, M_GT, M_PIPE, M_LINE, M_BLOCK,
    M_BLOCKSTAR, M_Q_IN, M_Q_ESC, M_Q_CLOSE
  } mode_t;

  localparam int MAX_TOK = 4;

  // classified request from front to back: which tokens it made
  typedef struct packed {
    logic [2:0]  count;
    logic        close_en;
    kind_t       close_kind;
    logic        close_at_byte;
    logic        single_en;
    kind_t       single_kind;
    logic        flush_en;
    kind_t       flush_kind;
    logic        fin;
  } cls_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction
  function automatic logic is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction
  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_dig(c);
  endfunction
  function automatic logic is_hex(input logic [7:0] c);
    return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

endpackage

@@ src/sqt_front.sv @@
// sqt_front: per-byte scanner state machine, classifies each request
// into closed tokens and their offsets; uses sqt_pkg
module sqt_front #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sqt_pkg::sqt_in_t       in_data,
  output logic                   q_valid,
  input  logic                   q_ready,
  output sqt_pkg::cls_t          q_cls,
  output logic [OFFSET_BITS-1:0] q_pend,
  output logic [OFFSET_BITS-1:0] q_off
);
  import sqt_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  mode_t                  scan_mode, scan_mode_next;
  logic [OFFSET_BITS-1:0] pending_start, pending_start_next;
  logic [OFFSET_BITS-1:0] byte_offset;
  kind_t                  last_kind, last_kind_next;
  logic                   hex_mode, hex_mode_next;
  logic [1:0]             quote_sel, quote_sel_next;
  cls_t                   cls;
  logic                   acc;

  logic [7:0] c;
  logic       fin;
  logic       fed;
  mode_t      fmode;
  logic       fhex;
  logic       close_en, close_at;
  kind_t      close_kind;
  logic       st_single;
  kind_t      st_kind;
  mode_t      st_mode;
  kind_t      lk_mid;
  mode_t      m_after;
  kind_t      fk;
  logic [7:0] qc;
  kind_t      qok, qbad;

  assign c   = in_data.text_byte;
  assign fin = in_data.final_byte;
  assign in_ready = q_ready;
  assign acc = in_valid && in_ready;

  always_comb begin
    unique case (quote_sel)
      2'd1:    begin qc = 8'h22; qok = K_QID;    qbad = K_ERR_DQ; end
      2'd2:    begin qc = 8'h60; qok = K_QID;    qbad = K_ERR_BQ; end
      default: begin qc = 8'h27; qok = K_STRING; qbad = K_ERR_SQ; end
    endcase
  end

  // feed the open token
  always_comb begin
    logic mark, nd;
    fed = 1'b1;
    fmode = scan_mode;
    fhex = hex_mode;
    close_en = 1'b0;
    close_at = 1'b0;
    close_kind = K_EOS;
    nd = 1'b0;
    mark = 1'b0;
    unique case (scan_mode)
      M_IDLE: fed = 1'b0;
      M_WS: if (!is_ws(c)) begin fed = 0; close_en = 1; close_kind = K_WS; end
      M_WORD: if (!is_word(c)) begin fed = 0; close_en = 1; close_kind = K_WORD; end
      M_ZERO, M_INT, M_FRAC: begin
        if (scan_mode == M_ZERO && !fin && (c == "x" || c == "X")) begin
          fhex = 1'b1;
          fmode = M_INT;
        end else begin
          nd = fhex ? is_hex(c) : is_dig(c);
          mark = fhex ? (c == "p" || c == "P") : (c == "e" || c == "E");
          if (scan_mode != M_FRAC) fmode = M_INT;
          if (nd) begin
          end else if (scan_mode != M_FRAC && c == ".") fmode = M_FRAC;
          else if (!fin && mark) fmode = M_ESIGN;
          else if (is_word(c)) fmode = M_BAD;
          else begin fed = 0; close_en = 1; close_kind = K_NUMBER; end
        end
      end
      M_ESIGN, M_EDIG, M_AFTERDOT: begin
        if (scan_mode == M_ESIGN) fmode = M_EDIG;
        if (scan_mode == M_ESIGN && !fin && (c == "+" || c == "-")) begin
        end else if (is_dig(c)) begin
        end else if (is_word(c)) fmode = M_BAD;
        else begin fed = 0; close_en = 1; close_kind = K_NUMBER; end
      end
      M_BAD: if (!is_word(c)) begin fed = 0; close_en = 1; close_kind = K_ERR_NUM; end
      M_DOTPEND:
        if (is_dig(c)) fmode = M_DN_INT;
        else begin fed = 0; close_en = 1; close_kind = K_DOT; end
      M_DN_INT:
        if (is_dig(c)) begin
        end else if (!fin && (c == "e" || c == "E")) fmode = M_DN_ESIGN;
        else begin fed = 0; close_en = 1; close_kind = K_NUMBER; end
      M_DN_ESIGN, M_DN_EDIG: begin
        fmode = M_DN_EDIG;
        if (scan_mode == M_DN_ESIGN && !fin && (c == "+" || c == "-")) begin
        end else if (!is_dig(c)) begin
          fed = 0; close_en = 1; close_kind = K_NUMBER;
        end
      end
      M_MINUS:
        if (c == ">") begin close_en = 1; close_at = 1; close_kind = K_ARROW; end
        else if (c == "-") fmode = M_LINE;
        else begin fed = 0; close_en = 1; close_kind = K_MINUS; end
      M_SLASH:
        if (c == "/") fmode = M_LINE;
        else if (c == "*") fmode = M_BLOCK;
        else begin fed = 0; close_en = 1; close_kind = K_SLASH; end
      M_EQ: begin
        close_en = 1; close_kind = K_EQ;
        if (c == "=") close_at = 1; else fed = 0;
      end
      M_BANG:
        if (c == "=") begin close_en = 1; close_at = 1; close_kind = K_NE; end
        else begin fed = 0; close_en = 1; close_kind = K_ERR_BANG; end
      M_LT:
        if (c == "=") begin close_en = 1; close_at = 1; close_kind = K_LE; end
        else if (c == ">") begin close_en = 1; close_at = 1; close_kind = K_NE; end
        else begin fed = 0; close_en = 1; close_kind = K_LT; end
      M_GT: begin
        close_en = 1;
        if (c == "=") begin close_at = 1; close_kind = K_GE; end
        else begin fed = 0; close_kind = K_GT; end
      end
      M_PIPE:
        if (c == "|") begin close_en = 1; close_at = 1; close_kind = K_CONCAT; end
        else begin fed = 0; close_en = 1; close_kind = K_ERR_PIPE; end
      M_LINE: if (c == 8'h0a) begin fed = 0; close_en = 1; close_kind = K_COMMENT; end
      M_BLOCK: if (c == "*") fmode = M_BLOCKSTAR;
      M_BLOCKSTAR:
        if (c == "/") begin close_en = 1; close_at = 1; close_kind = K_COMMENT; end
        else if (c != "*") fmode = M_BLOCK;
      M_Q_IN:
        if (c == qc) fmode = M_Q_CLOSE;
        else if (c == 8'h5c) fmode = M_Q_ESC;
      M_Q_ESC: fmode = M_Q_IN;
      M_Q_CLOSE:
        if (c == qc) fmode = M_Q_IN;
        else begin fed = 0; close_en = 1; close_kind = qok; end
      default: fed = 1'b0;
    endcase
  end

  assign lk_mid = (close_en && close_kind != K_WS && close_kind != K_COMMENT)
                  ? close_kind : last_kind;

  // start a new token at this byte
  always_comb begin
    st_single = 1'b0;
    st_kind = K_ERR;
    st_mode = M_IDLE;
    quote_sel_next = quote_sel;
    if (is_ws(c)) st_mode = M_WS;
    else if (is_alpha(c)) st_mode = M_WORD;
    else if (is_dig(c))
      st_mode = (lk_mid == K_DOT) ? M_AFTERDOT : ((c == "0") ? M_ZERO : M_INT);
    else begin
      unique case (c)
        8'h27: begin quote_sel_next = 2'd0; st_mode = M_Q_IN; end
        8'h22: begin quote_sel_next = 2'd1; st_mode = M_Q_IN; end
        8'h60: begin quote_sel_next = 2'd2; st_mode = M_Q_IN; end
        ".":
          if (byte_offset == '0) st_mode = M_DN_INT;
          else if (fin || lk_mid == K_RPAR || lk_mid == K_RSQ || lk_mid == K_WORD ||
                   lk_mid == K_QID || lk_mid == K_NUMBER) begin
            st_single = 1; st_kind = K_DOT;
          end else st_mode = M_DOTPEND;
        "-": st_mode = M_MINUS;
        "/": st_mode = M_SLASH;
        "=": st_mode = M_EQ;
        "!": st_mode = M_BANG;
        "<": st_mode = M_LT;
        ">": st_mode = M_GT;
        "|": st_mode = M_PIPE;
        "(": begin st_single = 1; st_kind = K_LPAR; end
        ")": begin st_single = 1; st_kind = K_RPAR; end
        "[": begin st_single = 1; st_kind = K_LSQ; end
        "]": begin st_single = 1; st_kind = K_RSQ; end
        ",": begin st_single = 1; st_kind = K_COMMA; end
        ";": begin st_single = 1; st_kind = K_SEMI; end
        "+": begin st_single = 1; st_kind = K_PLUS; end
        "*": begin st_single = 1; st_kind = K_STAR; end
        "%": begin st_single = 1; st_kind = K_PERCENT; end
        "?": begin st_single = 1; st_kind = K_QMARK; end
        ":": begin st_single = 1; st_kind = K_COLON; end
        default: begin st_single = 1; st_kind = K_ERR; end
      endcase
    end
  end

  always_comb begin
    unique case (m_after)
      M_WS:     fk = K_WS;
      M_WORD:   fk = K_WORD;
      M_BAD:    fk = K_ERR_NUM;
      M_DOTPEND: fk = K_DOT;
      M_MINUS:  fk = K_MINUS;
      M_SLASH:  fk = K_SLASH;
      M_EQ:     fk = K_EQ;
      M_BANG:   fk = K_ERR_BANG;
      M_LT:     fk = K_LT;
      M_GT:     fk = K_GT;
      M_PIPE:   fk = K_ERR_PIPE;
      M_LINE:   fk = K_COMMENT;
      M_BLOCK, M_BLOCKSTAR: fk = K_ERR_BLOCK;
      M_Q_IN, M_Q_ESC: fk = (fed ? qbad : ((quote_sel_next == 2'd1) ? K_ERR_DQ :
                             (quote_sel_next == 2'd2) ? K_ERR_BQ : K_ERR_SQ));
      M_Q_CLOSE: fk = qok;
      default:  fk = K_NUMBER;
    endcase
  end

  always_comb begin
    kind_t lk;
    logic [2:0] n;
    m_after = fed ? (close_at ? M_IDLE : fmode) : (st_single ? M_IDLE : st_mode);
    hex_mode_next = (!fed && is_dig(c)) ? 1'b0 : fhex;
    pending_start_next = fed ? pending_start : byte_offset;
    lk = lk_mid;
    if (!fed && st_single) lk = st_kind;
    cls.close_en = close_en;
    cls.close_kind = close_kind;
    cls.close_at_byte = close_at;
    cls.single_en = !fed && st_single;
    cls.single_kind = st_kind;
    cls.flush_en = fin && m_after != M_IDLE;
    cls.flush_kind = fk;
    cls.fin = fin;
    if (cls.flush_en && fk != K_WS && fk != K_COMMENT) lk = fk;
    n = 3'(close_en) + 3'(cls.single_en) + 3'(cls.flush_en) + 3'(fin);
    cls.count = n;
    last_kind_next = fin ? K_WS : lk;
    scan_mode_next = fin ? M_IDLE : m_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= M_IDLE;
      pending_start <= '0;
      byte_offset <= '0;
      last_kind <= K_WS;
      hex_mode <= 1'b0;
      quote_sel <= 2'd0;
    end else if (acc) begin
      scan_mode <= scan_mode_next;
      last_kind <= last_kind_next;
      hex_mode <= fin ? 1'b0 : hex_mode_next;
      quote_sel <= (fin || fed) ? (fin ? 2'd0 : quote_sel) : quote_sel_next;
      pending_start <= fin ? '0 : pending_start_next;
      byte_offset <= fin ? '0 : (byte_offset == OFF_MAX ? OFF_MAX : byte_offset + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) q_valid <= 1'b0;
    else if (q_ready) q_valid <= acc && cls.count != 3'd0;
  end

  // closed token starts at the old start, an open one at the new start
  always_ff @(posedge clk) begin
    if (acc) begin
      q_cls <= cls;
      q_pend <= close_en ? pending_start : pending_start_next;
      q_off <= byte_offset;
    end
  end
endmodule

@@ src/sqt_back.sv @@
// sqt_back: two-entry queue of classified requests and token emitter,
// one token per cycle while out_ready is high; uses sqt_pkg
module sqt_back #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  sqt_pkg::cls_t          q_cls,
  input  logic [OFFSET_BITS-1:0] q_pend,
  input  logic [OFFSET_BITS-1:0] q_off,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sqt_pkg::sqt_out_t      out_data
);
  import sqt_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  typedef struct packed {
    cls_t                   cls;
    logic [OFFSET_BITS-1:0] pend;
    logic [OFFSET_BITS-1:0] off;
  } ent_t;

  ent_t       fifo [2];
  logic       wp, rp;
  logic [1:0] used;
  logic [1:0] sub;
  logic       push, pop, step;
  ent_t       h;
  logic [OFFSET_BITS-1:0] nxt;
  kind_t      kd [MAX_TOK];
  logic [OFFSET_BITS-1:0] fa [MAX_TOK];
  logic [OFFSET_BITS-1:0] pa [MAX_TOK];
  logic [2:0] nt;

  assign q_ready = used != 2'd2;
  assign push = q_valid && q_ready;
  assign h = fifo[rp];
  assign nxt = (h.off == OFF_MAX) ? OFF_MAX : h.off + 1'b1;
  assign step = used != 2'd0 && (!out_valid || out_ready);
  assign pop = step && ({1'b0, sub} + 3'd1 == h.cls.count);

  // list the tokens of the head request in order
  always_comb begin
    nt = 3'd0;
    for (int i = 0; i < MAX_TOK; i++) begin
      kd[i] = K_EOS; fa[i] = nxt; pa[i] = nxt;
    end
    if (h.cls.close_en) begin
      kd[0] = h.cls.close_kind; fa[0] = h.pend;
      pa[0] = h.cls.close_at_byte ? nxt : h.off;
      nt = 3'd1;
    end
    if (h.cls.single_en) begin
      kd[nt[1:0]] = h.cls.single_kind; fa[nt[1:0]] = h.off; pa[nt[1:0]] = nxt;
      nt = nt + 3'd1;
    end
    if (h.cls.flush_en) begin
      kd[nt[1:0]] = h.cls.flush_kind;
      fa[nt[1:0]] = h.cls.close_en ? h.off : h.pend;
      pa[nt[1:0]] = nxt;
      nt = nt + 3'd1;
    end
    if (h.cls.fin) begin
      kd[nt[1:0]] = K_EOS; fa[nt[1:0]] = nxt; pa[nt[1:0]] = nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wp] <= '{cls: q_cls, pend: q_pend, off: q_off};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; used <= 2'd0; sub <= 2'd0; out_valid <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      used <= used + 2'(push) - 2'(pop);
      if (step) sub <= pop ? 2'd0 : sub + 2'd1;
      if (step) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data.token_kind <= kd[sub];
      out_data.token_first <= 32'(fa[sub]);
      out_data.token_past_end <= 32'(pa[sub]);
      out_data.run_last <= pop;
    end
  end
endmodule

@@ src/sql_query_tokenizer.sv @@
// sql_query_tokenizer: top level, front scanner feeding the token emitter
// through a short request queue; uses sqt_pkg, sqt_front, sqt_back
//
// Accepts one text byte per cycle while in_ready is high. Each byte yields
// zero to three tokens; the emitter sends one token per cycle unless
// out_ready stalls it, and the two-entry queue absorbs bursts. Input rate
// is one byte per cycle when bytes make at most one token each and out_ready is high.
module sql_query_tokenizer #(
  parameter int OFFSET_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sqt_pkg::sqt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sqt_pkg::sqt_out_t out_data
);
  import sqt_pkg::*;

  logic                   q_valid, q_ready;
  cls_t                   q_cls;
  logic [OFFSET_BITS-1:0] q_pend, q_off;

  sqt_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_cls, .q_pend, .q_off
  );

  sqt_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cls, .q_pend, .q_off,
    .out_valid, .out_ready, .out_data
  );

  a_eos_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.token_kind == K_EOS |-> out_data.run_last)
    else $error("end of stream token not last");
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.token_kind != K_EOS |->
      out_data.token_first <= out_data.token_past_end)
    else $error("token offsets reversed");
  a_eos_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.token_kind == K_EOS |->
      out_data.token_first == out_data.token_past_end)
    else $error("end of stream token not empty");
endmodule
